// File: hw/rtl/cfsd_pkg.sv
// shared types, codes and helper functions for the can frame signal dispatcher
// no dependencies; used by every module of the block except cfsd_ram
package cfsd_pkg;

    // input operation codes
    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_TABLE = 1'b1;

    // sensor table word select codes
    localparam logic [1:0] WORD_ID       = 2'd0;
    localparam logic [1:0] WORD_LAYOUT   = 2'd1;
    localparam logic [1:0] WORD_COND_VAL = 2'd2;
    localparam logic [1:0] WORD_COND_EN  = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_START_ID   = 3'd0;
    localparam logic [2:0] CFG_START_SPEC = 3'd1;
    localparam logic [2:0] CFG_STOP_ID    = 3'd2;
    localparam logic [2:0] CFG_STOP_SPEC  = 3'd3;
    localparam logic [2:0] CFG_LAT_ID     = 3'd4;
    localparam logic [2:0] CFG_LONG_ID    = 3'd5;
    localparam logic [2:0] CFG_TIME_ID    = 3'd6;
    localparam logic [2:0] CFG_COUNT      = 3'd7;

    localparam logic [3:0] DLC_FULL   = 4'd8;
    localparam int         TABLE_MAX  = 16;
    localparam int         QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        KIND_IGNORED = 3'd0,
        KIND_START   = 3'd1,
        KIND_STOP    = 3'd2,
        KIND_LAT     = 3'd3,
        KIND_LONG    = 3'd4,
        KIND_TIME    = 3'd5,
        KIND_SENSOR  = 3'd6
    } t_kind;

    typedef enum logic [1:0] {
        CLS_WRITE  = 2'd0,
        CLS_DIRECT = 2'd1,
        CLS_SCAN   = 2'd2
    } t_cls;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_SCAN   = 2'd1,
        ST_FINISH = 2'd2
    } t_state;

    typedef struct packed {
        logic [28:0] start_id;
        logic [14:0] start_spec;
        logic [28:0] stop_id;
        logic [14:0] stop_spec;
        logic [28:0] lat_id;
        logic [28:0] long_id;
        logic [28:0] time_id;
        logic [4:0]  count;
    } t_cfg;

    // classified item between front and back; data holds the table value on writes
    typedef struct packed {
        t_cls        cls;
        t_kind       kind;
        logic [28:0] id;
        logic [3:0]  dlc;
        logic [63:0] data;
        logic [3:0]  slot;
        logic [1:0]  word;
    } t_qent;

    typedef struct packed {
        t_kind       kind;
        logic        last;
        logic [3:0]  sensor_index;
        logic [31:0] value;
        logic [15:0] coord_sign;
        logic [15:0] coord_characteristic;
        logic        gps_fix;
        logic [7:0]  gps_speed;
        logic [7:0]  gps_hour;
        logic [7:0]  gps_minute;
        logic [7:0]  gps_second;
        logic [23:0] gps_date;
    } t_result;

    function automatic logic [7:0] f_byte(input logic [63:0] d, input logic [2:0] k);
        f_byte = d[{k, 3'b000} +: 8];
    endfunction

    // single result of a frame that needs no table scan, or the ignored result of a scan with no match
    function automatic t_result f_direct(input t_kind kind, input logic [63:0] d);
        t_result res;
        res      = '0;
        res.kind = kind;
        res.last = 1'b1;
        unique case (kind)
            KIND_LAT, KIND_LONG: begin
                res.value                = d[63:32];
                res.coord_sign           = d[15:0];
                res.coord_characteristic = d[31:16];
            end
            KIND_TIME: begin
                res.gps_fix    = (d[7:0] == 8'd1);
                res.gps_speed  = d[15:8];
                res.gps_hour   = d[47:40];
                res.gps_minute = d[55:48];
                res.gps_second = d[63:56];
                res.gps_date   = d[39:16];
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    function automatic t_result f_sensor(input logic [3:0] idx, input logic [31:0] val,
                                         input logic last);
        t_result res;
        res              = '0;
        res.kind         = KIND_SENSOR;
        res.last         = last;
        res.sensor_index = idx;
        res.value        = val;
        return res;
    endfunction

endpackage

// File: hw/rtl/cfsd_ram.sv
// generic single write port ram with registered read
// no dependencies
module cfsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/cfsd_front.sv
// front end: takes input items and classifies frames against the configured ids
// depends on cfsd_pkg
module cfsd_front (
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_op,
    input  logic [28:0]        i_frame_id,
    input  logic [3:0]         i_frame_dlc,
    input  logic [63:0]        i_frame_data,
    input  logic [3:0]         i_table_slot,
    input  logic [1:0]         i_table_word,
    input  logic [63:0]        i_table_value,
    input  cfsd_pkg::t_cfg     i_cfg,
    input  logic               i_q_full,
    output logic               o_push,
    output cfsd_pkg::t_qent    o_ent
);

    logic start_hit;
    logic stop_hit;
    logic start_ok;
    logic stop_ok;
    logic coord_hit;
    logic time_hit;

    assign start_hit = (i_frame_id == i_cfg.start_id) && (i_frame_dlc == i_cfg.start_spec[14:11]);
    assign stop_hit  = (i_frame_id == i_cfg.stop_id) && (i_frame_dlc == i_cfg.stop_spec[14:11]);
    assign start_ok  = cfsd_pkg::f_byte(i_frame_data, i_cfg.start_spec[10:8])
                       == i_cfg.start_spec[7:0];
    assign stop_ok   = cfsd_pkg::f_byte(i_frame_data, i_cfg.stop_spec[10:8])
                       == i_cfg.stop_spec[7:0];
    assign coord_hit = ((i_frame_id == i_cfg.lat_id) || (i_frame_id == i_cfg.long_id))
                       && (i_frame_dlc == cfsd_pkg::DLC_FULL);
    assign time_hit  = (i_frame_id == i_cfg.time_id) && (i_frame_dlc == cfsd_pkg::DLC_FULL);

    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    always_comb begin
        o_ent      = '0;
        o_ent.id   = i_frame_id;
        o_ent.dlc  = i_frame_dlc;
        o_ent.data = i_frame_data;
        o_ent.slot = i_table_slot;
        o_ent.word = i_table_word;
        o_ent.kind = cfsd_pkg::KIND_IGNORED;
        o_ent.cls  = cfsd_pkg::CLS_SCAN;
        priority if (i_op == cfsd_pkg::OP_TABLE) begin
            o_ent.cls  = cfsd_pkg::CLS_WRITE;
            o_ent.data = i_table_value;
        end else if (start_hit) begin
            // a byte mismatch still ends the checks with an ignored result
            o_ent.cls  = cfsd_pkg::CLS_DIRECT;
            o_ent.kind = start_ok ? cfsd_pkg::KIND_START : cfsd_pkg::KIND_IGNORED;
        end else if (stop_hit) begin
            o_ent.cls  = cfsd_pkg::CLS_DIRECT;
            o_ent.kind = stop_ok ? cfsd_pkg::KIND_STOP : cfsd_pkg::KIND_IGNORED;
        end else if (coord_hit) begin
            o_ent.cls  = cfsd_pkg::CLS_DIRECT;
            o_ent.kind = (i_frame_id == i_cfg.lat_id) ? cfsd_pkg::KIND_LAT
                                                      : cfsd_pkg::KIND_LONG;
        end else if (time_hit) begin
            o_ent.cls  = cfsd_pkg::CLS_DIRECT;
            o_ent.kind = cfsd_pkg::KIND_TIME;
        end else begin
            o_ent.cls  = cfsd_pkg::CLS_SCAN;
        end
    end

endmodule

// File: hw/rtl/cfsd_queue.sv
// short fifo of classified items between front and back
// depends on cfsd_pkg
module cfsd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cfsd_pkg::t_qent i_ent,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output cfsd_pkg::t_qent o_head
);

    localparam int PW = (cfsd_pkg::QUEUE_DEPTH > 1) ? $clog2(cfsd_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(cfsd_pkg::QUEUE_DEPTH + 1);

    cfsd_pkg::t_qent r_mem [cfsd_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [PW-1:0]   n_rd_ptr;
    logic [CW-1:0]   r_cnt;
    logic [CW-1:0]   n_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_cnt == CW'(cfsd_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(cfsd_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(cfsd_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_ent;
        end
    end

endmodule

// File: hw/rtl/cfsd_back.sv
// back end: table writes, sensor table scan and the result output register
// depends on cfsd_pkg and cfsd_ram
module cfsd_back #(
    parameter int SENSOR_SLOTS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cfsd_pkg::t_cfg    i_cfg,
    input  logic              i_q_valid,
    input  cfsd_pkg::t_qent   i_q_head,
    output logic              o_q_pop,
    output cfsd_pkg::t_result o_out,
    output logic              o_out_valid,
    input  logic              i_out_ready
);

    localparam int AW = (SENSOR_SLOTS > 1) ? $clog2(SENSOR_SLOTS) : 1;
    localparam int MAX_SCAN = (SENSOR_SLOTS < cfsd_pkg::TABLE_MAX) ? SENSOR_SLOTS
                                                                   : cfsd_pkg::TABLE_MAX;

    cfsd_pkg::t_state  r_state;
    cfsd_pkg::t_state  n_state;
    cfsd_pkg::t_qent   r_cur;
    cfsd_pkg::t_qent   n_cur;
    logic [AW-1:0]     r_eval_idx;
    logic [AW-1:0]     n_eval_idx;
    logic              r_pend_vld;
    logic              n_pend_vld;
    logic [AW-1:0]     r_pend_idx;
    logic [AW-1:0]     n_pend_idx;
    logic [31:0]       r_pend_val;
    logic [31:0]       n_pend_val;
    cfsd_pkg::t_result r_out;
    cfsd_pkg::t_result n_out;
    logic              r_out_vld;
    logic              n_out_vld;

    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic              wr_en;
    logic              slot_ok;
    logic [28:0]       q_id;
    logic [19:0]       q_lay;
    logic [63:0]       q_cv;
    logic [7:0]        q_ce;
    logic [4:0]        scan_cnt;
    logic [3:0]        lim;
    logic              m_any;
    logic              m_cond_ok;
    logic [31:0]       m_val;
    logic              match;
    logic              out_free;
    logic              at_end;

    assign slot_ok  = 7'(i_q_head.slot) < 7'(SENSOR_SLOTS);
    assign wr_addr  = AW'(i_q_head.slot);
    assign scan_cnt = (i_cfg.count > 5'(MAX_SCAN)) ? 5'(MAX_SCAN) : i_cfg.count;
    assign out_free = !r_out_vld || i_out_ready;
    assign at_end   = (7'(r_eval_idx) == (7'(scan_cnt) - 7'd1));

    cfsd_ram #(.WIDTH(29), .DEPTH(SENSOR_SLOTS)) u_ram_id (
        .i_clk   (i_clk),
        .i_we    (wr_en && (i_q_head.word == cfsd_pkg::WORD_ID)),
        .i_waddr (wr_addr),
        .i_wdata (i_q_head.data[28:0]),
        .i_raddr (rd_addr),
        .o_rdata (q_id)
    );

    cfsd_ram #(.WIDTH(20), .DEPTH(SENSOR_SLOTS)) u_ram_layout (
        .i_clk   (i_clk),
        .i_we    (wr_en && (i_q_head.word == cfsd_pkg::WORD_LAYOUT)),
        .i_waddr (wr_addr),
        .i_wdata (i_q_head.data[19:0]),
        .i_raddr (rd_addr),
        .o_rdata (q_lay)
    );

    cfsd_ram #(.WIDTH(64), .DEPTH(SENSOR_SLOTS)) u_ram_cond_val (
        .i_clk   (i_clk),
        .i_we    (wr_en && (i_q_head.word == cfsd_pkg::WORD_COND_VAL)),
        .i_waddr (wr_addr),
        .i_wdata (i_q_head.data),
        .i_raddr (rd_addr),
        .o_rdata (q_cv)
    );

    cfsd_ram #(.WIDTH(8), .DEPTH(SENSOR_SLOTS)) u_ram_cond_en (
        .i_clk   (i_clk),
        .i_we    (wr_en && (i_q_head.word == cfsd_pkg::WORD_COND_EN)),
        .i_waddr (wr_addr),
        .i_wdata (i_q_head.data[7:0]),
        .i_raddr (rd_addr),
        .o_rdata (q_ce)
    );

    // match of the entry whose read data is on the ram outputs
    always_comb begin
        m_any     = 1'b0;
        m_cond_ok = 1'b1;
        m_val     = '0;
        lim       = (r_cur.dlc > cfsd_pkg::DLC_FULL) ? cfsd_pkg::DLC_FULL : r_cur.dlc;
        for (int k = 0; k < 4; k++) begin
            // position 8 and up is unassigned
            if (!q_lay[4 + 4 * k + 3]) begin
                m_any          = 1'b1;
                m_val[8 * k +: 8] = cfsd_pkg::f_byte(r_cur.data, q_lay[4 + 4 * k +: 3]);
            end
        end
        for (int k = 0; k < 8; k++) begin
            if ((4'(k) < lim) && q_ce[k] && (q_cv[8 * k +: 8] != r_cur.data[8 * k +: 8])) begin
                m_cond_ok = 1'b0;
            end
        end
        match = (q_id == r_cur.id) && (q_lay[3:0] == r_cur.dlc) && m_any && m_cond_ok;
    end

    always_comb begin
        n_state    = r_state;
        n_cur      = r_cur;
        n_eval_idx = r_eval_idx;
        n_pend_vld = r_pend_vld;
        n_pend_idx = r_pend_idx;
        n_pend_val = r_pend_val;
        n_out      = r_out;
        n_out_vld  = r_out_vld && !i_out_ready;
        o_q_pop    = 1'b0;
        wr_en      = 1'b0;
        rd_addr    = '0;
        unique case (r_state)
            cfsd_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    unique case (i_q_head.cls)
                        cfsd_pkg::CLS_WRITE: begin
                            wr_en   = slot_ok;
                            o_q_pop = 1'b1;
                        end
                        cfsd_pkg::CLS_DIRECT: begin
                            if (out_free) begin
                                n_out     = cfsd_pkg::f_direct(i_q_head.kind, i_q_head.data);
                                n_out_vld = 1'b1;
                                o_q_pop   = 1'b1;
                            end
                        end
                        cfsd_pkg::CLS_SCAN: begin
                            // entry 0 is being read this cycle
                            o_q_pop    = 1'b1;
                            n_cur      = i_q_head;
                            n_pend_vld = 1'b0;
                            n_eval_idx = '0;
                            n_state    = (scan_cnt == '0) ? cfsd_pkg::ST_FINISH
                                                          : cfsd_pkg::ST_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            cfsd_pkg::ST_SCAN: begin
                // a match is held back until the next one proves it is not the last
                if (match && r_pend_vld && !out_free) begin
                    rd_addr = r_eval_idx;
                end else begin
                    rd_addr = r_eval_idx + AW'(1);
                    if (match) begin
                        if (r_pend_vld) begin
                            n_out     = cfsd_pkg::f_sensor(4'(r_pend_idx), r_pend_val, 1'b0);
                            n_out_vld = 1'b1;
                        end
                        n_pend_vld = 1'b1;
                        n_pend_idx = r_eval_idx;
                        n_pend_val = m_val;
                    end
                    if (at_end) begin
                        n_state = cfsd_pkg::ST_FINISH;
                    end else begin
                        n_eval_idx = r_eval_idx + AW'(1);
                    end
                end
            end
            cfsd_pkg::ST_FINISH: begin
                if (out_free) begin
                    n_out     = r_pend_vld
                                ? cfsd_pkg::f_sensor(4'(r_pend_idx), r_pend_val, 1'b1)
                                : cfsd_pkg::f_direct(cfsd_pkg::KIND_IGNORED, '0);
                    n_out_vld = 1'b1;
                    n_state   = cfsd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cfsd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= cfsd_pkg::ST_IDLE;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_eval_idx <= n_eval_idx;
        r_pend_idx <= n_pend_idx;
        r_pend_val <= n_pend_val;
        r_out      <= n_out;
    end

    assign o_out       = r_out;
    assign o_out_valid = r_out_vld;

endmodule

// File: hw/rtl/can_frame_signal_dispatcher.sv
// A button or gps frame, or a button frame failing its byte check, passes the queue and the
// result output register. Any other frame scans min(sensor_count, 16, SENSOR_SLOTS) table
// entries, one per cycle unless a match meets a held match while the output is busy, over the
// single read port of the table rams, holding the back end until its finish state ends. Table
// writes pass 1 per cycle, direct frames 1 per cycle while the output is free. Reset clears
// configuration, queue and output; the sensor table is undefined until written.
module can_frame_signal_dispatcher #(
    parameter int SENSOR_SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_op,
    input  logic [28:0] i_frame_id,
    input  logic [3:0]  i_frame_dlc,
    input  logic [63:0] i_frame_data,
    input  logic [3:0]  i_table_slot,
    input  logic [1:0]  i_table_word,
    input  logic [63:0] i_table_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_kind,
    output logic        o_last,
    output logic [3:0]  o_sensor_index,
    output logic [31:0] o_value,
    output logic [15:0] o_coord_sign,
    output logic [15:0] o_coord_characteristic,
    output logic        o_gps_fix,
    output logic [7:0]  o_gps_speed,
    output logic [7:0]  o_gps_hour,
    output logic [7:0]  o_gps_minute,
    output logic [7:0]  o_gps_second,
    output logic [23:0] o_gps_date,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [28:0] i_cfg_wdata
);

    cfsd_pkg::t_cfg    r_cfg;
    cfsd_pkg::t_cfg    n_cfg;
    cfsd_pkg::t_qent   push_ent;
    cfsd_pkg::t_qent   q_head;
    cfsd_pkg::t_result res;
    logic              push;
    logic              q_full;
    logic              q_valid;
    logic              q_pop;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cfsd_pkg::CFG_START_ID:   n_cfg.start_id   = i_cfg_wdata;
                cfsd_pkg::CFG_START_SPEC: n_cfg.start_spec = i_cfg_wdata[14:0];
                cfsd_pkg::CFG_STOP_ID:    n_cfg.stop_id    = i_cfg_wdata;
                cfsd_pkg::CFG_STOP_SPEC:  n_cfg.stop_spec  = i_cfg_wdata[14:0];
                cfsd_pkg::CFG_LAT_ID:     n_cfg.lat_id     = i_cfg_wdata;
                cfsd_pkg::CFG_LONG_ID:    n_cfg.long_id    = i_cfg_wdata;
                cfsd_pkg::CFG_TIME_ID:    n_cfg.time_id    = i_cfg_wdata;
                cfsd_pkg::CFG_COUNT:      n_cfg.count      = i_cfg_wdata[4:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    cfsd_front u_front (
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_op          (i_op),
        .i_frame_id    (i_frame_id),
        .i_frame_dlc   (i_frame_dlc),
        .i_frame_data  (i_frame_data),
        .i_table_slot  (i_table_slot),
        .i_table_word  (i_table_word),
        .i_table_value (i_table_value),
        .i_cfg         (r_cfg),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_ent         (push_ent)
    );

    cfsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ent   (push_ent),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    cfsd_back #(.SENSOR_SLOTS(SENSOR_SLOTS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_q_head    (q_head),
        .o_q_pop     (q_pop),
        .o_out       (res),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready)
    );

    assign o_kind                 = res.kind;
    assign o_last                 = res.last;
    assign o_sensor_index         = res.sensor_index;
    assign o_value                = res.value;
    assign o_coord_sign           = res.coord_sign;
    assign o_coord_characteristic = res.coord_characteristic;
    assign o_gps_fix              = res.gps_fix;
    assign o_gps_speed            = res.gps_speed;
    assign o_gps_hour             = res.gps_hour;
    assign o_gps_minute           = res.gps_minute;
    assign o_gps_second           = res.gps_second;
    assign o_gps_date             = res.gps_date;

endmodule
